[rtl/core/gcf_pkg.sv]
// ----------------------------------------------------------------------------
// gcf_pkg - shared types and constants for the course-from-fixes block
// Fixed-point angle constants, CORDIC arctangent table and command struct.
// ----------------------------------------------------------------------------
package gcf_pkg;

  // Datapath width of the shared CORDIC unit (x, y and angle accumulator)
  localparam int DW = 40;
  // Width of stored sin/cos values and Q30 products (magnitudes stay below 2^31)
  localparam int QW = 32;
  // Index width of the arctangent table
  localparam int ATAN_IDX_W = 5;

  localparam int CORDIC_STEPS_DEF = 20;

  // Angles in 1e-7 degree
  localparam logic signed [DW-1:0] QUARTER_TURN = 40'sd900000000;
  localparam logic signed [DW-1:0] HALF_TURN    = 40'sd1800000000;
  localparam logic signed [DW-1:0] FULL_TURN    = 40'sd3600000000;
  // CORDIC start vector, Q30
  localparam logic signed [DW-1:0] CORDIC_GAIN_Q30 = 40'sd652032874;

  // Output scaling: 1e-7 degree to 0.01 degree, rounded half up.
  // n / 100000 = (n >> 5) / 3125; the divide by 3125 is a reciprocal multiply,
  // exact for dividends below 2^29.
  localparam logic [33:0] ROUND_BIAS  = 34'd3600050000; // full turn + half step
  localparam logic [28:0] RECIP_3125  = 29'd351843721;  // ceil(2^40 / 3125)
  localparam int          RECIP_SHIFT = 40;
  localparam logic [15:0] COURSE_WRAP = 16'd36000;

  typedef struct packed {
    logic start;
    logic vector_mode; // 1: atan2 (vectoring), 0: sin/cos (rotation)
  } cordic_cmd_t;

  // atan(2^-i) in 1e-7 degree, rounded to nearest
  function automatic logic signed [DW-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [DW-1:0] v;
    unique case (idx)
      5'd0:  v = 40'sd450000000;
      5'd1:  v = 40'sd265650512;
      5'd2:  v = 40'sd140362435;
      5'd3:  v = 40'sd71250163;
      5'd4:  v = 40'sd35763344;
      5'd5:  v = 40'sd17899106;
      5'd6:  v = 40'sd8951737;
      5'd7:  v = 40'sd4476142;
      5'd8:  v = 40'sd2238105;
      5'd9:  v = 40'sd1119057;
      5'd10: v = 40'sd559529;
      5'd11: v = 40'sd279765;
      5'd12: v = 40'sd139882;
      5'd13: v = 40'sd69941;
      5'd14: v = 40'sd34971;
      5'd15: v = 40'sd17485;
      5'd16: v = 40'sd8743;
      5'd17: v = 40'sd4371;
      5'd18: v = 40'sd2186;
      5'd19: v = 40'sd1093;
      5'd20: v = 40'sd546;
      5'd21: v = 40'sd273;
      5'd22: v = 40'sd137;
      5'd23: v = 40'sd68;
      5'd24: v = 40'sd34;
      5'd25: v = 40'sd17;
      5'd26: v = 40'sd9;
      5'd27: v = 40'sd4;
      5'd28: v = 40'sd2;
      5'd29: v = 40'sd1;
      5'd30: v = 40'sd1;
      5'd31: v = 40'sd0;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/core/gated_course_from_fixes.sv]
// ----------------------------------------------------------------------------
// gated_course_from_fixes - great-circle initial course from successive fixes
// Stores the last valid fix and reports the bearing to each new one that passes the gate.
// ----------------------------------------------------------------------------
// One transaction in carries a fix; one transaction out carries fix_ok, the
// course in 0.01 degree (0 = north, clockwise, 0..35999) and course_computed.
// The course is computed only when a previous valid fix exists, ground_speed
// is strictly above min_speed and the position changed; otherwise it is 0 and
// the sequencer goes from idle straight to the done state. For a computed
// course one shared CORDIC unit runs three sin/cos rotations and one atan2
// vectoring pass, one multiplier forms the four Q30 products, and one
// reciprocal multiply scales the angle to 0.01 degree. in_ready is high only
// while the sequencer idles; a finished result sits in the output register
// while the next fix is taken. min_speed resets to 100 and may be written
// while the block is idle.
module gated_course_from_fixes import gcf_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // fix input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               fix_valid,
  input  logic signed [30:0] latitude,
  input  logic signed [31:0] longitude,
  input  logic        [16:0] ground_speed,
  // result output
  output logic               out_valid,
  input  logic               out_ready,
  output logic               fix_ok,
  output logic        [15:0] course,
  output logic               course_computed,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [16:0] min_speed
);

  typedef enum logic [3:0] {
    S_IDLE, S_REDUCE, S_SC_GO, S_SC_WAIT, S_MUL, S_PREP,
    S_AT_WAIT, S_DIV, S_MOD, S_DONE
  } state_t;

  state_t state;

  // configuration and stored fix
  logic [16:0]        speed_min;
  logic signed [30:0] prev_latitude;
  logic signed [31:0] prev_longitude;
  logic               have_previous;

  // working registers
  logic signed [30:0] lat1, lat2;
  logic signed [33:0] dlon;       // longitude difference, 1e-7 degree
  logic [1:0]         sc_sel;     // 0: lat1, 1: lat2, 2: dlon
  logic               flip;
  logic signed [QW-1:0] c1, s1, c2, s2, cd, sd;
  logic [1:0]         mstep;
  logic signed [QW-1:0] py, p2, p3, p4;
  logic [33:0]        rem;
  logic [15:0]        quo;
  logic               w_fix_ok;
  logic [15:0]        w_course;
  logic               w_computed;

  // CORDIC interface
  cordic_cmd_t          cmd;
  logic signed [DW-1:0] cx0, cy0, cz0;
  logic                 c_done;
  logic signed [DW-1:0] cx, cy, cz;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  gcf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .x0   (cx0),
    .y0   (cy0),
    .z0   (cz0),
    .done (c_done),
    .x    (cx),
    .y    (cy),
    .z    (cz)
  );

  // shared multiplier: Q30 x Q30, floor shift by 30
  logic signed [QW-1:0]   mul_a, mul_b;
  logic signed [2*QW-1:0] prod;
  logic signed [QW-1:0]   prod_q30;

  always_comb begin
    case (mstep)
      2'd0:    begin mul_a = sd; mul_b = c2; end
      2'd1:    begin mul_a = c1; mul_b = s2; end
      2'd2:    begin mul_a = s1; mul_b = c2; end
      default: begin mul_a = p3; mul_b = cd; end
    endcase
  end

  assign prod     = (2*QW)'(mul_a) * (2*QW)'(mul_b);
  assign prod_q30 = QW'(prod >>> 30);

  // rotation angle for the selected sin/cos pass, folded into +-90 degree
  logic signed [DW-1:0] ang_src, ang_fold;
  logic                 ang_flip;

  always_comb begin
    case (sc_sel)
      2'd0:    ang_src = DW'(lat1);
      2'd1:    ang_src = DW'(lat2);
      default: ang_src = DW'(dlon);
    endcase
    ang_flip = 1'b1;
    if (ang_src > QUARTER_TURN)       ang_fold = ang_src - HALF_TURN;
    else if (ang_src < -QUARTER_TURN) ang_fold = ang_src + HALF_TURN;
    else begin
      ang_fold = ang_src;
      ang_flip = 1'b0;
    end
  end

  // atan2 operands
  logic signed [DW-1:0] vx, vy;
  assign vx = DW'(p2) - DW'(p4);
  assign vy = DW'(py);

  // scaled angle / 100000: drop 5 bits, then multiply by the 3125 reciprocal
  logic [57:0] scale_prod;
  assign scale_prod = 58'(rem[33:5]) * 58'(RECIP_3125);

  logic signed [DW-1:0] cs_c, cs_s;
  assign cs_c = flip ? -cx : cx;
  assign cs_s = flip ? -cy : cy;

  logic accept_go;
  assign accept_go = fix_valid && have_previous && (ground_speed > speed_min) &&
                     !(prev_latitude == latitude && prev_longitude == longitude);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      speed_min     <= 17'd100;
      prev_latitude <= '0;
      prev_longitude <= '0;
      have_previous <= 1'b0;
      out_valid     <= 1'b0;
      cmd           <= '0;
      sc_sel        <= '0;
      mstep         <= '0;
    end else begin
      cmd.start <= 1'b0;
      if (cfg_valid && cfg_ready) speed_min <= min_speed;
      if (out_valid && out_ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            w_fix_ok   <= fix_valid;
            w_course   <= '0;
            w_computed <= 1'b0;
            lat1 <= prev_latitude;
            lat2 <= latitude;
            dlon <= 34'(longitude) - 34'(prev_longitude);
            if (fix_valid) begin
              prev_latitude  <= latitude;
              prev_longitude <= longitude;
              have_previous  <= 1'b1;
            end
            state <= accept_go ? S_REDUCE : S_DONE;
          end
        end
        S_REDUCE: begin
          // bring the difference into (-180, 180] degree
          if (DW'(dlon) > HALF_TURN)        dlon <= 34'(DW'(dlon) - FULL_TURN);
          else if (DW'(dlon) <= -HALF_TURN) dlon <= 34'(DW'(dlon) + FULL_TURN);
          sc_sel <= 2'd0;
          state  <= S_SC_GO;
        end
        S_SC_GO: begin
          cmd.start       <= 1'b1;
          cmd.vector_mode <= 1'b0;
          cx0  <= CORDIC_GAIN_Q30;
          cy0  <= '0;
          cz0  <= ang_fold;
          flip <= ang_flip;
          state <= S_SC_WAIT;
        end
        S_SC_WAIT: begin
          if (c_done) begin
            case (sc_sel)
              2'd0:    begin c1 <= QW'(cs_c); s1 <= QW'(cs_s); end
              2'd1:    begin c2 <= QW'(cs_c); s2 <= QW'(cs_s); end
              default: begin cd <= QW'(cs_c); sd <= QW'(cs_s); end
            endcase
            if (sc_sel == 2'd2) begin
              mstep <= 2'd0;
              state <= S_MUL;
            end else begin
              sc_sel <= sc_sel + 2'd1;
              state  <= S_SC_GO;
            end
          end
        end
        S_MUL: begin
          case (mstep)
            2'd0:    py <= prod_q30;
            2'd1:    p2 <= prod_q30;
            2'd2:    p3 <= prod_q30;
            default: p4 <= prod_q30;
          endcase
          mstep <= mstep + 2'd1;
          if (mstep == 2'd3) state <= S_PREP;
        end
        S_PREP: begin
          if (vx == '0 && vy == '0) begin
            // degenerate vector: bearing zero
            rem   <= ROUND_BIAS;
            state <= S_DIV;
          end else begin
            cmd.start       <= 1'b1;
            cmd.vector_mode <= 1'b1;
            if (vx < 0 && vy >= 0) begin
              cx0 <= vy; cy0 <= -vx; cz0 <= QUARTER_TURN;
            end else if (vx < 0) begin
              cx0 <= -vy; cy0 <= vx; cz0 <= -QUARTER_TURN;
            end else begin
              cx0 <= vx; cy0 <= vy; cz0 <= '0;
            end
            state <= S_AT_WAIT;
          end
        end
        S_AT_WAIT: begin
          if (c_done) begin
            rem   <= 34'(cz + DW'(ROUND_BIAS));
            state <= S_DIV;
          end
        end
        S_DIV: begin
          quo   <= 16'(scale_prod >> RECIP_SHIFT);
          state <= S_MOD;
        end
        S_MOD: begin
          w_course   <= (quo >= COURSE_WRAP) ? quo - COURSE_WRAP : quo;
          w_computed <= 1'b1;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid       <= 1'b1;
            fix_ok          <= w_fix_ok;
            course          <= w_course;
            course_computed <= w_computed;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_course_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> course < COURSE_WRAP)
    else $error("course out of range");

  a_computed_needs_fix: assert property (@(posedge clk) disable iff (rst)
    out_valid && course_computed |-> fix_ok)
    else $error("course computed for invalid fix");

  a_plain_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !course_computed |-> course == '0)
    else $error("nonzero course without computation");

  a_cordic_done_waited: assert property (@(posedge clk) disable iff (rst)
    c_done |-> (state == S_SC_WAIT || state == S_AT_WAIT))
    else $error("CORDIC finished outside a wait state");

endmodule

[rtl/core/gcf_cordic.sv]
// ----------------------------------------------------------------------------
// gcf_cordic - iterative CORDIC, rotation or vectoring
// One micro-rotation per cycle; done pulses after STEPS iterations.
// ----------------------------------------------------------------------------
module gcf_cordic import gcf_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cordic_cmd_t          cmd,
  input  logic signed [DW-1:0] x0,
  input  logic signed [DW-1:0] y0,
  input  logic signed [DW-1:0] z0,
  output logic                 done,
  output logic signed [DW-1:0] x,
  output logic signed [DW-1:0] y,
  output logic signed [DW-1:0] z
);

  localparam int CW = $clog2(STEPS);

  logic          running;
  logic          mode;
  logic [CW-1:0] cnt;

  logic                 sub; // rotate by negative direction term
  logic signed [DW-1:0] xs, ys, at;

  assign xs = x >>> cnt;
  assign ys = y >>> cnt;
  assign at = atan_lut(ATAN_IDX_W'(cnt));
  // rotation follows sign of z, vectoring drives y toward zero
  assign sub = mode ? y[DW-1] : ~z[DW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        running <= 1'b1;
        mode    <= cmd.vector_mode;
        cnt     <= '0;
        x       <= x0;
        y       <= y0;
        z       <= z0;
      end else if (running) begin
        if (sub) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - at;
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + at;
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule
